@@ rtl/kfts_pkg.sv @@
package kfts_pkg;

  localparam int PC_W = 6;
  localparam logic [PC_W-1:0] PC_UPD = 6'd36;

  typedef enum logic [1:0] {
    CMD_PREDICT = 2'd0,
    CMD_UPDATE  = 2'd1,
    CMD_BOTH    = 2'd2,
    CMD_NONE    = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    STAT_OK   = 2'd0,
    STAT_SKIP = 2'd1,
    STAT_SAT  = 2'd2
  } status_t;

  typedef enum logic [3:0] {
    CFG_TRANS_00    = 4'd0,
    CFG_TRANS_01    = 4'd1,
    CFG_TRANS_10    = 4'd2,
    CFG_TRANS_11    = 4'd3,
    CFG_PNOISE_00   = 4'd4,
    CFG_PNOISE_X    = 4'd5,
    CFG_PNOISE_11   = 4'd6,
    CFG_MEAS_NOISE  = 4'd7
  } cfg_idx_t;

  typedef enum logic [1:0] {
    ALU_ADD = 2'd0,
    ALU_SUB = 2'd1,
    ALU_MUL = 2'd2,
    ALU_DIV = 2'd3
  } alu_op_t;

  typedef struct packed {
    logic    start;
    alu_op_t op;
  } alu_req_t;

  typedef struct packed {
    logic done;
    logic sat;
  } alu_rsp_t;

  typedef enum logic [2:0] {
    OP_MUL  = 3'd0,
    OP_ADD  = 3'd1,
    OP_SUB  = 3'd2,
    OP_DIV  = 3'd3,
    OP_CHK  = 3'd4,
    OP_ENDP = 3'd5,
    OP_END  = 3'd6
  } op_t;

  typedef enum logic [4:0] {
    R_ZERO, R_F00, R_F01, R_F10, R_F11, R_Q00, R_Q01, R_Q11, R_R,
    R_X0, R_X1, R_P00, R_P01, R_P10, R_P11, R_K0, R_K1,
    R_Z, R_Y, R_S, R_T1, R_T2, R_A00, R_A01, R_A10, R_A11, R_N0
  } opd_t;

  typedef struct packed {
    op_t  op;
    opd_t a;
    opd_t b;
    opd_t d;
  } uop_t;

  function automatic uop_t ucode(input logic [PC_W-1:0] pc);
    uop_t u;
    case (pc)
      6'd0:  u = '{OP_MUL, R_F00, R_X0,   R_T1};
      6'd1:  u = '{OP_MUL, R_F01, R_X1,   R_T2};
      6'd2:  u = '{OP_ADD, R_T1,  R_T2,   R_N0};
      6'd3:  u = '{OP_MUL, R_F10, R_X0,   R_T1};
      6'd4:  u = '{OP_MUL, R_F11, R_X1,   R_T2};
      6'd5:  u = '{OP_ADD, R_T1,  R_T2,   R_X1};
      6'd6:  u = '{OP_ADD, R_N0,  R_ZERO, R_X0};
      6'd7:  u = '{OP_MUL, R_F00, R_P00,  R_T1};
      6'd8:  u = '{OP_MUL, R_F01, R_P10,  R_T2};
      6'd9:  u = '{OP_ADD, R_T1,  R_T2,   R_A00};
      6'd10: u = '{OP_MUL, R_F00, R_P01,  R_T1};
      6'd11: u = '{OP_MUL, R_F01, R_P11,  R_T2};
      6'd12: u = '{OP_ADD, R_T1,  R_T2,   R_A01};
      6'd13: u = '{OP_MUL, R_F10, R_P00,  R_T1};
      6'd14: u = '{OP_MUL, R_F11, R_P10,  R_T2};
      6'd15: u = '{OP_ADD, R_T1,  R_T2,   R_A10};
      6'd16: u = '{OP_MUL, R_F10, R_P01,  R_T1};
      6'd17: u = '{OP_MUL, R_F11, R_P11,  R_T2};
      6'd18: u = '{OP_ADD, R_T1,  R_T2,   R_A11};
      6'd19: u = '{OP_MUL, R_A00, R_F00,  R_T1};
      6'd20: u = '{OP_MUL, R_A01, R_F01,  R_T2};
      6'd21: u = '{OP_ADD, R_T1,  R_T2,   R_T1};
      6'd22: u = '{OP_ADD, R_T1,  R_Q00,  R_P00};
      6'd23: u = '{OP_MUL, R_A00, R_F10,  R_T1};
      6'd24: u = '{OP_MUL, R_A01, R_F11,  R_T2};
      6'd25: u = '{OP_ADD, R_T1,  R_T2,   R_T1};
      6'd26: u = '{OP_ADD, R_T1,  R_Q01,  R_P01};
      6'd27: u = '{OP_MUL, R_A10, R_F00,  R_T1};
      6'd28: u = '{OP_MUL, R_A11, R_F01,  R_T2};
      6'd29: u = '{OP_ADD, R_T1,  R_T2,   R_T1};
      6'd30: u = '{OP_ADD, R_T1,  R_Q01,  R_P10};
      6'd31: u = '{OP_MUL, R_A10, R_F10,  R_T1};
      6'd32: u = '{OP_MUL, R_A11, R_F11,  R_T2};
      6'd33: u = '{OP_ADD, R_T1,  R_T2,   R_T1};
      6'd34: u = '{OP_ADD, R_T1,  R_Q11,  R_P11};
      6'd35: u = '{OP_ENDP, R_ZERO, R_ZERO, R_ZERO};
      6'd36: u = '{OP_SUB, R_Z,   R_X0,   R_Y};
      6'd37: u = '{OP_ADD, R_P00, R_R,    R_S};
      6'd38: u = '{OP_CHK, R_S,   R_ZERO, R_ZERO};
      6'd39: u = '{OP_DIV, R_P00, R_S,    R_K0};
      6'd40: u = '{OP_DIV, R_P10, R_S,    R_K1};
      6'd41: u = '{OP_MUL, R_K0,  R_Y,    R_T1};
      6'd42: u = '{OP_ADD, R_X0,  R_T1,   R_X0};
      6'd43: u = '{OP_MUL, R_K1,  R_Y,    R_T1};
      6'd44: u = '{OP_ADD, R_X1,  R_T1,   R_X1};
      6'd45: u = '{OP_MUL, R_K1,  R_P00,  R_T1};
      6'd46: u = '{OP_MUL, R_K1,  R_P01,  R_T2};
      6'd47: u = '{OP_SUB, R_P10, R_T1,   R_P10};
      6'd48: u = '{OP_SUB, R_P11, R_T2,   R_P11};
      6'd49: u = '{OP_MUL, R_K0,  R_P00,  R_T1};
      6'd50: u = '{OP_SUB, R_P00, R_T1,   R_P00};
      6'd51: u = '{OP_MUL, R_K0,  R_P01,  R_T1};
      6'd52: u = '{OP_SUB, R_P01, R_T1,   R_P01};
      default: u = '{OP_END, R_ZERO, R_ZERO, R_ZERO};
    endcase
    return u;
  endfunction

endpackage

@@ rtl/kalman_filter_two_state_unit.sv @@
// Two-state Kalman filter, one shared serial multiply/divide/add unit under a microcode sequencer.
// A skipped update stops early.
// One item at a time: the next input is taken the cycle after the result register loads.
// The serial unit (one bit per cycle in multiply and divide) sets how long each item takes.
// Synchronous active-high reset clears state, gains, handshakes and loads default registers.
module kalman_filter_two_state_unit import kfts_pkg::*; #(
  parameter int WORD_WIDTH = 32,
  parameter int FRAC_BITS  = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [3:0]         cfg_index,
  input  logic [31:0]        cfg_data,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         cmd,
  input  logic signed [31:0] measurement,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] est_position_out,
  output logic signed [31:0] est_velocity_out,
  output logic signed [31:0] gain_position_out,
  output logic signed [31:0] gain_velocity_out,
  output logic signed [31:0] pos_variance_out,
  output logic [1:0]         status
);

  localparam int W  = WORD_WIDTH;
  localparam int EW = (W > 33) ? W : 33;
  localparam int LW = (W > 32) ? W : 32;
  localparam logic signed [W-1:0] WMAX = {1'b0, {(W-1){1'b1}}};
  localparam logic signed [W-1:0] WMIN = {1'b1, {(W-1){1'b0}}};
  localparam logic signed [W-1:0] ONE_W =
    (FRAC_BITS >= W-1) ? WMAX : (W'(1) << FRAC_BITS);
  localparam logic signed [31:0] O_MAX = 32'sh7fffffff;
  localparam logic signed [31:0] O_MIN = 32'sh80000000;

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_ISSUE = 4'b0010,
    S_WAIT  = 4'b0100,
    S_OUT   = 4'b1000
  } state_t;

  state_t state;
  logic [PC_W-1:0] pc;
  logic [1:0] cmd_r;
  logic satf, skip;

  logic signed [W-1:0] f00, f01, f10, f11, q00, q01, q11, rn;
  logic signed [W-1:0] x0, x1, p00, p01, p10, p11, k0, k1;
  logic signed [W-1:0] z, yv, s, t1, t2, a00, a01, a10, a11, n0;

  uop_t uop;
  alu_req_t req;
  alu_rsp_t rsp;
  logic signed [W-1:0] alu_a, alu_b, alu_y;

  logic [W:0]  zc, cfg_s, cfg_u;
  logic [32:0] o0, o1, o2, o3, o4;
  logic        osat;

  function automatic logic [W:0] clamp_in(input logic signed [32:0] v);
    logic signed [EW-1:0] e;
    e = EW'(v);
    if (e > EW'(WMAX)) return {1'b1, WMAX};
    else if (e < EW'(WMIN)) return {1'b1, WMIN};
    else return {1'b0, e[W-1:0]};
  endfunction

  function automatic logic [32:0] clamp_out(input logic signed [W-1:0] v);
    logic signed [LW-1:0] e;
    e = LW'(v);
    if (e > LW'(O_MAX)) return {1'b1, O_MAX};
    else if (e < LW'(O_MIN)) return {1'b1, O_MIN};
    else return {1'b0, e[31:0]};
  endfunction

  function automatic logic signed [W-1:0] rd(input opd_t c);
    case (c)
      R_F00: return f00;
      R_F01: return f01;
      R_F10: return f10;
      R_F11: return f11;
      R_Q00: return q00;
      R_Q01: return q01;
      R_Q11: return q11;
      R_R:   return rn;
      R_X0:  return x0;
      R_X1:  return x1;
      R_P00: return p00;
      R_P01: return p01;
      R_P10: return p10;
      R_P11: return p11;
      R_K0:  return k0;
      R_K1:  return k1;
      R_Z:   return z;
      R_Y:   return yv;
      R_S:   return s;
      R_T1:  return t1;
      R_T2:  return t2;
      R_A00: return a00;
      R_A01: return a01;
      R_A10: return a10;
      R_A11: return a11;
      R_N0:  return n0;
      default: return '0;
    endcase
  endfunction

  assign uop = ucode(pc);
  assign alu_a = rd(uop.a);
  assign alu_b = rd(uop.b);

  always_comb begin
    req.start = 1'b0;
    req.op    = ALU_ADD;
    if (state == S_ISSUE) begin
      case (uop.op)
        OP_MUL: begin req.start = 1'b1; req.op = ALU_MUL; end
        OP_ADD: begin req.start = 1'b1; req.op = ALU_ADD; end
        OP_SUB: begin req.start = 1'b1; req.op = ALU_SUB; end
        OP_DIV: begin req.start = 1'b1; req.op = ALU_DIV; end
        default: req.start = 1'b0;
      endcase
    end
  end

  kfts_alu #(.WORD_WIDTH(WORD_WIDTH), .FRAC_BITS(FRAC_BITS)) u_alu (
    .clk (clk),
    .rst (rst),
    .req (req),
    .a   (alu_a),
    .b   (alu_b),
    .rsp (rsp),
    .y   (alu_y)
  );

  assign cfg_ready = 1'b1;
  assign in_ready  = (state == S_IDLE);
  assign zc    = clamp_in({measurement[31], measurement});
  assign cfg_s = clamp_in({cfg_data[31], cfg_data});
  assign cfg_u = clamp_in({2'b00, cfg_data[30:0]});
  assign o0 = clamp_out(x0);
  assign o1 = clamp_out(x1);
  assign o2 = clamp_out(k0);
  assign o3 = clamp_out(k1);
  assign o4 = clamp_out(p00);
  assign osat = o0[32] | o1[32] | o2[32] | o3[32] | o4[32];

  always_ff @(posedge clk) begin
    if (rst) begin
      f00 <= ONE_W;
      f01 <= '0;
      f10 <= '0;
      f11 <= ONE_W;
      q00 <= '0;
      q01 <= '0;
      q11 <= '0;
      rn  <= ONE_W;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_TRANS_00:   f00 <= cfg_s[W-1:0];
        CFG_TRANS_01:   f01 <= cfg_s[W-1:0];
        CFG_TRANS_10:   f10 <= cfg_s[W-1:0];
        CFG_TRANS_11:   f11 <= cfg_s[W-1:0];
        CFG_PNOISE_00:  q00 <= cfg_u[W-1:0];
        CFG_PNOISE_X:   q01 <= cfg_s[W-1:0];
        CFG_PNOISE_11:  q11 <= cfg_u[W-1:0];
        CFG_MEAS_NOISE: rn  <= cfg_u[W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      pc        <= '0;
      cmd_r     <= CMD_PREDICT;
      satf      <= 1'b0;
      skip      <= 1'b0;
      out_valid <= 1'b0;
      x0 <= '0; x1 <= '0;
      p00 <= '0; p01 <= '0; p10 <= '0; p11 <= '0;
      k0 <= '0; k1 <= '0;
    end else begin
      if (out_valid && out_ready && (state != S_OUT)) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            cmd_r <= cmd;
            z     <= zc[W-1:0];
            satf  <= (cmd == CMD_NONE) ? 1'b0 : zc[W];
            skip  <= 1'b0;
            pc    <= (cmd == CMD_UPDATE) ? PC_UPD : PC_W'(0);
            if (cmd == CMD_NONE) begin
              state <= S_OUT;
            end else begin
              state <= S_ISSUE;
            end
          end
        end
        S_ISSUE: begin
          case (uop.op)
            OP_ENDP: begin
              if (cmd_r == CMD_PREDICT) state <= S_OUT;
              else pc <= pc + PC_W'(1);
            end
            OP_END: state <= S_OUT;
            OP_CHK: begin
              if (s <= 0) begin
                skip  <= 1'b1;
                state <= S_OUT;
              end else begin
                pc <= pc + PC_W'(1);
              end
            end
            default: state <= S_WAIT;
          endcase
        end
        S_WAIT: begin
          if (rsp.done) begin
            satf  <= satf | rsp.sat;
            pc    <= pc + PC_W'(1);
            state <= S_ISSUE;
            case (uop.d)
              R_X0:  x0  <= alu_y;
              R_X1:  x1  <= alu_y;
              R_P00: p00 <= alu_y;
              R_P01: p01 <= alu_y;
              R_P10: p10 <= alu_y;
              R_P11: p11 <= alu_y;
              R_K0:  k0  <= alu_y;
              R_K1:  k1  <= alu_y;
              R_Y:   yv  <= alu_y;
              R_S:   s   <= alu_y;
              R_T1:  t1  <= alu_y;
              R_T2:  t2  <= alu_y;
              R_A00: a00 <= alu_y;
              R_A01: a01 <= alu_y;
              R_A10: a10 <= alu_y;
              R_A11: a11 <= alu_y;
              R_N0:  n0  <= alu_y;
              default: ;
            endcase
          end
        end
        S_OUT: begin
          if (!out_valid || out_ready) begin
            out_valid         <= 1'b1;
            est_position_out  <= o0[31:0];
            est_velocity_out  <= o1[31:0];
            gain_position_out <= o2[31:0];
            gain_velocity_out <= o3[31:0];
            pos_variance_out  <= o4[31:0];
            status <= skip ? STAT_SKIP : ((satf | osat) ? STAT_SAT : STAT_OK);
            state  <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_busy_after_transfer: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input taken while busy");

  a_done_only_waiting: assert property (@(posedge clk) disable iff (rst)
    rsp.done |-> (state == S_WAIT))
    else $error("unit result outside wait");

  a_start_to_wait: assert property (@(posedge clk) disable iff (rst)
    req.start |=> (state == S_WAIT))
    else $error("issue did not enter wait");

  a_out_from_out_state: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == S_OUT))
    else $error("result shown outside output state");

endmodule

@@ rtl/kfts_alu.sv @@
module kfts_alu import kfts_pkg::*; #(
  parameter int WORD_WIDTH = 32,
  parameter int FRAC_BITS  = 16
) (
  input  logic                         clk,
  input  logic                         rst,
  input  alu_req_t                     req,
  input  logic signed [WORD_WIDTH-1:0] a,
  input  logic signed [WORD_WIDTH-1:0] b,
  output alu_rsp_t                     rsp,
  output logic signed [WORD_WIDTH-1:0] y
);

  localparam int W  = WORD_WIDTH;
  localparam int F  = FRAC_BITS;
  localparam int MW = (2*W+1 > W+F) ? 2*W+1 : W+F;
  localparam int CW = $clog2(W+F+1);
  localparam logic signed [W-1:0] WMAX = {1'b0, {(W-1){1'b1}}};
  localparam logic signed [W-1:0] WMIN = {1'b1, {(W-1){1'b0}}};
  localparam logic [MW-1:0] HALF = MW'(1) << (F-1);
  localparam logic [MW-1:0] LIM_P = MW'(WMAX);
  localparam logic [MW-1:0] LIM_N = LIM_P + MW'(1);

  typedef enum logic [3:0] {
    A_IDLE = 4'b0001,
    A_MUL  = 4'b0010,
    A_DIV  = 4'b0100,
    A_FIN  = 4'b1000
  } astate_t;

  astate_t state;
  logic [2*W:0]   prod;
  logic [W-1:0]   xm;
  logic [W-1:0]   den;
  logic [W-1:0]   rem;
  logic [W+F-1:0] nq;
  logic           neg;
  logic           is_mul;
  logic [CW-1:0]  cnt;
  logic           done;
  logic           sat;

  logic [W-1:0]   ma, mb;
  logic [W:0]     sum, dif;
  logic [W:0]     mstep;
  logic [W:0]     rem2;
  logic           ge;
  logic [MW-1:0]  mval, lim, mclamp;

  assign ma = a[W-1] ? (~a + W'(1)) : a;
  assign mb = b[W-1] ? (~b + W'(1)) : b;
  assign sum = {a[W-1], a} + {b[W-1], b};
  assign dif = {a[W-1], a} - {b[W-1], b};
  assign mstep = prod[2*W:W] + (prod[0] ? {1'b0, xm} : (W+1)'(0));
  assign rem2 = {rem, nq[W+F-1]};
  assign ge = rem2 >= {1'b0, den};

  always_comb begin
    if (is_mul) begin
      mval = (MW'(prod[2*W-1:0]) + HALF) >> F;
    end else begin
      mval = MW'(nq);
    end
    lim = neg ? LIM_N : LIM_P;
    mclamp = (mval > lim) ? lim : mval;
  end

  assign rsp = '{done: done, sat: sat};

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= A_IDLE;
      done  <= 1'b0;
      sat   <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        A_IDLE: begin
          if (req.start) begin
            case (req.op)
              ALU_ADD: begin
                done <= 1'b1;
                sat  <= sum[W] != sum[W-1];
                y    <= (sum[W] != sum[W-1]) ? (sum[W] ? WMIN : WMAX) : sum[W-1:0];
              end
              ALU_SUB: begin
                done <= 1'b1;
                sat  <= dif[W] != dif[W-1];
                y    <= (dif[W] != dif[W-1]) ? (dif[W] ? WMIN : WMAX) : dif[W-1:0];
              end
              ALU_MUL: begin
                xm     <= ma;
                prod   <= {(W+1)'(0), mb};
                neg    <= a[W-1] ^ b[W-1];
                is_mul <= 1'b1;
                cnt    <= CW'(W);
                state  <= A_MUL;
              end
              default: begin
                nq     <= {ma, F'(0)};
                den    <= b;
                rem    <= '0;
                neg    <= a[W-1];
                is_mul <= 1'b0;
                cnt    <= CW'(W+F);
                state  <= A_DIV;
              end
            endcase
          end
        end
        A_MUL: begin
          prod <= {mstep, prod[W-1:0]} >> 1;
          cnt  <= cnt - CW'(1);
          if (cnt == CW'(1)) begin
            state <= A_FIN;
          end
        end
        A_DIV: begin
          rem <= ge ? W'(rem2 - {1'b0, den}) : rem2[W-1:0];
          nq  <= {nq[W+F-2:0], ge};
          cnt <= cnt - CW'(1);
          if (cnt == CW'(1)) begin
            state <= A_FIN;
          end
        end
        A_FIN: begin
          done  <= 1'b1;
          sat   <= mval > lim;
          y     <= neg ? (~mclamp[W-1:0] + W'(1)) : mclamp[W-1:0];
          state <= A_IDLE;
        end
        default: state <= A_IDLE;
      endcase
    end
  end

endmodule
